FILE: design/dlpc_pkg.sv
// Shared types, constants and the letter pattern for the datagram length and pattern checker.
// Depends on nothing; every other design file refers to it by scoped names.
`default_nettype none
package dlpc_pkg;

  localparam int unsigned PatternLen = 24;
  localparam int unsigned IndexWidth = 5;
  localparam logic [15:0] HdrBytes = 16'd2;
  localparam logic [15:0] CountMax = 16'hFFFF;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_SHORT  = 3'd1,
    ST_BUFFER = 3'd2,
    ST_LENGTH = 3'd3,
    ST_FORMAT = 3'd4
  } status_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data_byte;
    logic       byte_present;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] decl_length;
    logic [15:0] payload_length;
  } result_t;

  function automatic logic [7:0] pattern_letter(input logic [IndexWidth-1:0] idx);
    logic [7:0] letter;
    case (idx)
      5'd0:    letter = 8'h41;
      5'd1:    letter = 8'h42;
      5'd2:    letter = 8'h43;
      5'd3:    letter = 8'h44;
      5'd4:    letter = 8'h45;
      5'd5:    letter = 8'h46;
      5'd6:    letter = 8'h47;
      5'd7:    letter = 8'h48;
      5'd8:    letter = 8'h49;
      5'd9:    letter = 8'h4A;
      5'd10:   letter = 8'h4B;
      5'd11:   letter = 8'h4C;
      5'd12:   letter = 8'h4D;
      5'd13:   letter = 8'h4E;
      5'd14:   letter = 8'h4F;
      5'd15:   letter = 8'h50;
      5'd16:   letter = 8'h52;
      5'd17:   letter = 8'h53;
      5'd18:   letter = 8'h54;
      5'd19:   letter = 8'h55;
      5'd20:   letter = 8'h57;
      5'd21:   letter = 8'h58;
      5'd22:   letter = 8'h59;
      5'd23:   letter = 8'h5A;
      default: letter = 8'h41;
    endcase
    return letter;
  endfunction

endpackage
`default_nettype wire

FILE: design/dlpc_in_stage.sv
// Input register of the checker: holds one accepted word until the core consumes it.
// Depends on dlpc_pkg for the item type.
`default_nettype none
module dlpc_in_stage (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [7:0]    data_byte,
  input  wire logic          byte_present,
  input  wire logic          last_byte,
  input  wire logic          advance,
  output dlpc_pkg::item_t    item
);

  logic       held;
  logic [7:0] data_q;
  logic       present_q;
  logic       last_q;

  assign in_ready = !held || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_ready) begin
      held <= in_valid;
    end
    if (in_valid && in_ready) begin
      data_q    <= data_byte;
      present_q <= byte_present;
      last_q    <= last_byte;
    end
  end

  always_comb begin
    item.valid        = held;
    item.data_byte    = data_q;
    item.byte_present = present_q;
    item.last_byte    = last_q;
  end

endmodule
`default_nettype wire

FILE: design/dlpc_core.sv
// Datagram state and status evaluation: counts bytes, collects the length header,
// checks payload bytes against the pattern and forms the status on the last word.
// Depends on dlpc_pkg for types, constants and the pattern table.
`default_nettype none
module dlpc_core (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire dlpc_pkg::item_t  item,
  input  wire logic             out_free,
  input  wire logic [15:0]      buffer_size,
  output logic                  advance,
  output logic                  load,
  output dlpc_pkg::result_t     result
);

  logic [15:0]                     byte_count;
  logic [15:0]                     length_header;
  logic [dlpc_pkg::IndexWidth-1:0] pattern_index;
  logic                            mismatch_seen;

  logic [15:0]                     byte_count_next;
  logic [15:0]                     length_header_next;
  logic [dlpc_pkg::IndexWidth-1:0] pattern_index_next;
  logic                            mismatch_seen_next;
  logic [dlpc_pkg::IndexWidth-1:0] idx;
  logic [dlpc_pkg::IndexWidth-1:0] idx_inc;
  logic [15:0]                     pay;

  assign advance = item.valid && (!item.last_byte || out_free);
  assign load    = advance && item.last_byte;

  always_comb begin
    byte_count_next    = byte_count;
    length_header_next = length_header;
    pattern_index_next = pattern_index;
    mismatch_seen_next = mismatch_seen;
    idx = (pattern_index < dlpc_pkg::IndexWidth'(dlpc_pkg::PatternLen)) ?
          pattern_index : '0;
    idx_inc = idx + 1'b1;
    if (item.byte_present) begin
      if (byte_count == 16'd0) begin
        length_header_next = {item.data_byte, 8'h00};
      end else if (byte_count == 16'd1) begin
        length_header_next = {length_header[15:8], item.data_byte};
      end else begin
        if (dlpc_pkg::pattern_letter(idx) != item.data_byte) begin
          mismatch_seen_next = 1'b1;
        end
        pattern_index_next = (idx_inc >= dlpc_pkg::IndexWidth'(dlpc_pkg::PatternLen)) ?
                             '0 : idx_inc;
      end
      if (byte_count != dlpc_pkg::CountMax) begin
        byte_count_next = byte_count + 16'd1;
      end
    end
  end

  always_comb begin
    pay = byte_count_next - dlpc_pkg::HdrBytes;
    if (byte_count_next < dlpc_pkg::HdrBytes) begin
      result.status          = dlpc_pkg::ST_SHORT;
      result.decl_length     = 16'd0;
      result.payload_length  = 16'd0;
    end else begin
      result.decl_length     = length_header_next;
      result.payload_length  = pay;
      if (length_header_next > buffer_size) begin
        result.status = dlpc_pkg::ST_BUFFER;
      end else if (length_header_next < dlpc_pkg::HdrBytes ||
                   (length_header_next - dlpc_pkg::HdrBytes) != pay) begin
        result.status = dlpc_pkg::ST_LENGTH;
      end else if (mismatch_seen_next) begin
        result.status = dlpc_pkg::ST_FORMAT;
      end else begin
        result.status = dlpc_pkg::ST_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count    <= '0;
      length_header <= '0;
      pattern_index <= '0;
      mismatch_seen <= 1'b0;
    end else if (advance) begin
      if (item.last_byte) begin
        byte_count    <= '0;
        length_header <= '0;
        pattern_index <= '0;
        mismatch_seen <= 1'b0;
      end else begin
        byte_count    <= byte_count_next;
        length_header <= length_header_next;
        pattern_index <= pattern_index_next;
        mismatch_seen <= mismatch_seen_next;
      end
    end
  end

endmodule
`default_nettype wire

FILE: design/dlpc_out_stage.sv
// Result register of the checker: holds one status word until the receiver takes it.
// Depends on dlpc_pkg for the result type.
`default_nettype none
module dlpc_out_stage (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 load,
  input  wire dlpc_pkg::result_t    result,
  output logic                      out_free,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [2:0]                status,
  output logic [15:0]               decl_length,
  output logic [15:0]               payload_length
);

  dlpc_pkg::result_t held;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= load;
    end
    if (load) begin
      held <= result;
    end
  end

  assign status          = 3'(held.status);
  assign decl_length     = held.decl_length;
  assign payload_length  = held.payload_length;

endmodule
`default_nettype wire

FILE: design/datagram_length_pattern_checker_top.sv
// Top level of the datagram length and pattern checker.
// Instantiates dlpc_in_stage, dlpc_core and dlpc_out_stage; uses dlpc_pkg.
//
// A datagram arrives as a run of words on the input channel (in_valid/in_ready),
// one byte per word, with last_byte set on the final word. A word with
// byte_present low carries no byte; with last_byte also set it closes the
// datagram, otherwise it is ignored. The first two bytes are the big-endian
// declared length; each later byte is checked against the letter pattern.
// On the last word one status word appears on the output channel
// (out_valid/out_ready) with the declared and payload lengths.
// A final word's status is loaded from the input register into the result
// register, which raises out_valid. One word is taken every cycle unless a
// final word waits. The user must write buffer_size through
// cfg_write_en/cfg_write_data only while idle; the block does not enforce
// this. Reset empties both registers, clears the datagram state and sets
// buffer_size to 512. When the receiver stalls, the result stays held and
// non-final words keep flowing; a final word waits in the input register,
// and in_ready stays low until the result register is free again.
`default_nettype none
module datagram_length_pattern_checker_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  data_byte,
  input  wire logic        byte_present,
  input  wire logic        last_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       status,
  output logic [15:0]      decl_length,
  output logic [15:0]      payload_length,
  input  wire logic        cfg_write_en,
  input  wire logic [15:0] cfg_write_data
);

  logic [15:0]       buffer_size;
  dlpc_pkg::item_t   item;
  dlpc_pkg::result_t result;
  logic              advance;
  logic              load;
  logic              out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_size <= 16'd512;
    end else if (cfg_write_en) begin
      buffer_size <= cfg_write_data;
    end
  end

  dlpc_in_stage u_in (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .data_byte    (data_byte),
    .byte_present (byte_present),
    .last_byte    (last_byte),
    .advance      (advance),
    .item         (item)
  );

  dlpc_core u_core (
    .clk         (clk),
    .rst         (rst),
    .item        (item),
    .out_free    (out_free),
    .buffer_size (buffer_size),
    .advance     (advance),
    .load        (load),
    .result      (result)
  );

  dlpc_out_stage u_out (
    .clk             (clk),
    .rst             (rst),
    .load            (load),
    .result          (result),
    .out_free        (out_free),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .status          (status),
    .decl_length     (decl_length),
    .payload_length  (payload_length)
  );

endmodule
`default_nettype wire

FILE: verif/testbench.sv
// Self-checking testbench for datagram_length_pattern_checker_top: drives datagrams word by word
// and checks every status word against a predictor kept inside this file.
// Depends on the design package dlpc_pkg and on the top level module.
`timescale 1ns / 1ps

module testbench;

  localparam logic [8*24-1:0] LetterSeq = "ABCDEFGHIJKLMNOPRSTUWXYZ";

  typedef struct {
    dlpc_pkg::status_t st;
    logic [15:0]       decl;
    logic [15:0]       pay;
  } dgram_status_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  data_byte;
  logic        byte_present;
  logic        last_byte;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  status;
  logic [15:0] decl_length;
  logic [15:0] payload_length;
  logic        cfg_write_en;
  logic [15:0] cfg_write_data;

  // Predictor state for the datagram in progress.
  logic [15:0] buf_limit;
  logic [15:0] dg_count;
  logic [15:0] dg_header;
  int          dg_letter_pos;
  bit          dg_bad_letter;

  dgram_status_t expected_status_q[$];
  logic [7:0]    frame_q[$];
  int            mismatch_count;
  int            words_sent;
  int            dgram_count;
  int            status_tally[5];
  int            buffer_settings;
  int            hold_request;
  bit            tx_calm;
  bit            rx_calm;

  datagram_length_pattern_checker_top uut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .data_byte       (data_byte),
    .byte_present    (byte_present),
    .last_byte       (last_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .status          (status),
    .decl_length     (decl_length),
    .payload_length  (payload_length),
    .cfg_write_en    (cfg_write_en),
    .cfg_write_data  (cfg_write_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic logic [7:0] letter_at(input int pos);
    return LetterSeq[8*(23-pos) +: 8];
  endfunction

  function automatic int idle_gap(input bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(4, 30);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  task automatic clear_dgram();
    dg_count = '0;
    dg_header = '0;
    dg_letter_pos = 0;
    dg_bad_letter = 1'b0;
  endtask

  task automatic absorb_word(input logic [7:0] d, input logic p, input logic l);
    dgram_status_t res;
    if (p) begin
      if (dg_count == 16'd0) begin
        dg_header = {d, 8'h00};
      end else if (dg_count == 16'd1) begin
        dg_header[7:0] = d;
      end else begin
        if (letter_at(dg_letter_pos) != d) dg_bad_letter = 1'b1;
        dg_letter_pos = (dg_letter_pos == 23) ? 0 : dg_letter_pos + 1;
      end
      if (dg_count != 16'hFFFF) dg_count++;
    end
    if (l) begin
      if (dg_count < 16'd2) begin
        res.st = dlpc_pkg::ST_SHORT;
        res.decl = '0;
        res.pay = '0;
      end else begin
        res.decl = dg_header;
        res.pay = dg_count - 16'd2;
        if (res.decl > buf_limit) begin
          res.st = dlpc_pkg::ST_BUFFER;
        end else if (res.decl < 16'd2 || res.decl - 16'd2 != res.pay) begin
          res.st = dlpc_pkg::ST_LENGTH;
        end else if (dg_bad_letter) begin
          res.st = dlpc_pkg::ST_FORMAT;
        end else begin
          res.st = dlpc_pkg::ST_OK;
        end
      end
      expected_status_q.push_back(res);
      status_tally[res.st]++;
      dgram_count++;
      clear_dgram();
    end
  endtask

  task automatic send_word(input logic [7:0] d, input logic p, input logic l);
    int gap;
    gap = idle_gap(tx_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= d;
    byte_present <= p;
    last_byte <= l;
    do @(posedge clk); while (!in_ready);
    absorb_word(d, p, l);
    if (p || l) words_sent++;
  endtask

  task automatic wait_all_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_status_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic set_buffer_size(input logic [15:0] v);
    cfg_write_en <= 1'b1;
    cfg_write_data <= v;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    buf_limit = v;
    buffer_settings++;
  endtask

  task automatic load_frame(input logic [15:0] decl, input int plen, input int bad_pos);
    logic [7:0] b;
    frame_q.delete();
    frame_q.push_back(decl[15:8]);
    frame_q.push_back(decl[7:0]);
    for (int k = 0; k < plen; k++) begin
      b = letter_at(k % 24);
      if (k == bad_pos) b = b ^ 8'($urandom_range(1, 255));
      frame_q.push_back(b);
    end
  endtask

  task automatic send_frame(input bit close_empty, input int idle_pct);
    int n;
    n = frame_q.size();
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < idle_pct) send_word(8'($urandom), 1'b0, 1'b0);
      send_word(frame_q[i], 1'b1, (i == n - 1) && !close_empty);
    end
    if (close_empty || n == 0) send_word(8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic random_frame();
    int r;
    int plen;
    int decl;
    int bad;
    r = $urandom_range(0, 99);
    frame_q.delete();
    if (r < 70) begin
      plen = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 120) : $urandom_range(0, 24);
      r = $urandom_range(0, 9);
      if (r == 0) begin
        decl = plen + 3;
      end else if (r == 1) begin
        decl = plen + 1;
      end else if (r == 2) begin
        decl = $urandom_range(0, 65535);
      end else if (r == 3) begin
        decl = buf_limit + $urandom_range(0, 1);
      end else begin
        decl = plen + 2;
      end
      bad = ($urandom_range(0, 3) == 0 && plen > 0) ? $urandom_range(0, plen - 1) : -1;
      load_frame(decl[15:0], plen, bad);
    end else if (r < 80) begin
      repeat ($urandom_range(0, 1)) frame_q.push_back(8'($urandom));
    end else if (r < 90) begin
      repeat ($urandom_range(2, 10)) frame_q.push_back(8'($urandom));
    end else begin
      load_frame(16'($urandom_range(0, 1)), $urandom_range(0, 4), -1);
    end
    send_frame($urandom_range(0, 99) < 15, 5);
  endtask

  task automatic test_directed();
    send_word(8'h00, 1'b0, 1'b1);
    send_word(8'hFF, 1'b1, 1'b1);
    load_frame(16'h0000, 0, -1);
    send_frame(1'b0, 0);
    load_frame(16'h0002, 0, -1);
    send_frame(1'b0, 0);
    send_word(8'hA5, 1'b0, 1'b0);
    load_frame(16'h0005, 3, -1);
    send_frame(1'b0, 0);
    load_frame(16'h0005, 3, 2);
    send_frame(1'b0, 0);
    load_frame(16'hFFFF, 0, -1);
    send_frame(1'b0, 0);
    load_frame(16'h0004, 2, -1);
    send_frame(1'b1, 0);
    wait_all_results();
  endtask

  task automatic test_buffer_limits();
    set_buffer_size(16'd2);
    load_frame(16'd2, 0, -1);
    send_frame(1'b0, 0);
    load_frame(16'd3, 1, -1);
    send_frame(1'b0, 0);
    wait_all_results();
    set_buffer_size(16'hFFFF);
    load_frame(16'hFFFF, 4, -1);
    send_frame(1'b0, 0);
    wait_all_results();
    set_buffer_size(16'd300);
    load_frame(16'd300, 298, -1);
    send_frame(1'b0, 0);
    load_frame(16'd301, 299, -1);
    send_frame(1'b0, 0);
    wait_all_results();
    set_buffer_size(16'd512);
  endtask

  task automatic test_backpressure();
    tx_calm = 1'b1;
    hold_request = 150;
    repeat (60) begin
      load_frame(16'($urandom_range(2, 4)), $urandom_range(0, 2), -1);
      send_frame(1'b0, 0);
    end
    wait_all_results();
    tx_calm = 1'b0;
  endtask

  task automatic test_random();
    logic [15:0] limits[5];
    int target;
    limits[0] = 16'hFFFF;
    limits[1] = 16'd2;
    limits[2] = 16'($urandom_range(2, 65535));
    limits[3] = 16'($urandom_range(20, 200));
    limits[4] = 16'd512;
    for (int ph = 0; ph < 5; ph++) begin
      set_buffer_size(limits[ph]);
      // The fourth setting runs with neither side idling.
      tx_calm = (ph == 3);
      rx_calm = (ph == 3);
      target = words_sent + 60;
      while (words_sent < target) random_frame();
      wait_all_results();
    end
    tx_calm = 1'b0;
    rx_calm = 1'b0;
  endtask

  initial begin : receiver
    int stall;
    int n;
    out_ready <= 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (hold_request > 0) begin
        n = hold_request;
        hold_request = 0;
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end else begin
        stall = idle_gap(rx_calm);
        if (stall > 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : check_results
    dgram_status_t want;
    if (rst === 1'b0 && out_valid && out_ready) begin
      if (expected_status_q.size() == 0) begin
        report_mismatch("unexpected status word, status", status, 0);
      end else begin
        want = expected_status_q.pop_front();
        if (status !== want.st) report_mismatch("status", status, want.st);
        if (decl_length !== want.decl) begin
          report_mismatch("decl_length", decl_length, want.decl);
        end
        if (payload_length !== want.pay) begin
          report_mismatch("payload_length", payload_length, want.pay);
        end
      end
    end
  end

  initial begin
    rst <= 1'b1;
    in_valid <= 1'b0;
    data_byte <= '0;
    byte_present <= 1'b0;
    last_byte <= 1'b0;
    cfg_write_en <= 1'b0;
    cfg_write_data <= '0;
    mismatch_count = 0;
    words_sent = 0;
    dgram_count = 0;
    buffer_settings = 0;
    hold_request = 0;
    tx_calm = 1'b0;
    rx_calm = 1'b0;
    for (int i = 0; i < 5; i++) status_tally[i] = 0;
    buf_limit = 16'd512;
    clear_dgram();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_buffer_limits();
    test_backpressure();
    test_random();

    $display("Sent %0d words in %0d datagrams over %0d buffer size settings.",
             words_sent, dgram_count, buffer_settings);
    $display("Statuses seen: ok %0d, too short %0d, over buffer %0d, length %0d, format %0d.",
             status_tally[dlpc_pkg::ST_OK], status_tally[dlpc_pkg::ST_SHORT],
             status_tally[dlpc_pkg::ST_BUFFER], status_tally[dlpc_pkg::ST_LENGTH],
             status_tally[dlpc_pkg::ST_FORMAT]);
    if (mismatch_count == 0 && expected_status_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
